### rtl/ssfm_pkg.sv
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types and constants for the streaming first-match substring search.
// ----------------------------------------------------------------------------
package ssfm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LINE_BITS_DEF   = 32;

    localparam int BYTE_W      = 8;
    localparam int LINE_OUT_W  = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_W       = 6;
    localparam int PAT_REGS    = 4;
    localparam int PAT_W       = PAT_REGS * CFG_DATA_W;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_PAT_LEN   = 3'd4
    } t_cfg_idx;

endpackage

### rtl/ssfm_if.sv
// ----------------------------------------------------------------------------
// ssfm_if
// Valid/ready channels: byte input, match result output, register writes.
// ----------------------------------------------------------------------------
interface ssfm_in_if
    import ssfm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_file;

    modport source (output valid, output data_byte, output last_of_file, input ready);
    modport sink   (input valid, input data_byte, input last_of_file, output ready);
endinterface

interface ssfm_out_if
    import ssfm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [LINE_OUT_W-1:0] line_number;

    modport source (output valid, output found, output line_number, input ready);
    modport sink   (input valid, input found, input line_number, output ready);
endinterface

interface ssfm_cfg_if
    import ssfm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ssfm_prefix_update.sv
// ----------------------------------------------------------------------------
// ssfm_prefix_update
// Shift-and step: per-byte compare mask, next prefix vector, full-match hit.
// ----------------------------------------------------------------------------
module ssfm_prefix_update
    import ssfm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic [PAT_W-1:0]       i_pattern,
    input  logic [LEN_W-1:0]       i_length,
    input  logic [PATTERN_MAX-1:0] i_vec,
    input  logic [BYTE_W-1:0]      i_byte,
    output logic [PATTERN_MAX-1:0] o_vec,
    output logic                   o_hit
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0] byte_mask;
    logic [LEN_W-1:0]       hit_idx;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            byte_mask[i] = (i_pattern[BYTE_W*i +: BYTE_W] == i_byte);
        end
    end

    assign o_vec = ((i_vec << 1) | PATTERN_MAX'(1)) & byte_mask;

    always_comb begin
        priority if (i_length == '0) begin
            hit_idx = '0;
        end else if (i_length > MAX_LEN) begin
            hit_idx = MAX_LEN - LEN_W'(1);
        end else begin
            hit_idx = i_length - LEN_W'(1);
        end
    end

    assign o_hit = o_vec[hit_idx[IDX_W-1:0]];

endmodule

### rtl/stream_substring_first_match.sv
// ----------------------------------------------------------------------------
// stream_substring_first_match
// Streaming first-match substring search over file bytes, with line count.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                       | handshake
//  i_in     | in  | data_byte[7:0], last_of_file  | valid/ready
//  o_out    | out | found, line_number[31:0]      | valid/ready
//  i_cfg    | in  | index[2:0], data[63:0]        | valid/ready (ready tied high)
//
//  One byte per cycle sustained unless a held output stalls it; each item
//  passes the input register and any result is registered in the output one.
//  Synchronous active-low reset clears pattern to zeros, length to 1 and the
//  per-file state. A stalled output holds its item and the input register
//  keeps accepting as long as the output register frees up.
// ----------------------------------------------------------------------------
module stream_substring_first_match
    import ssfm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssfm_in_if.sink     i_in,
    ssfm_out_if.source  o_out,
    ssfm_cfg_if.sink    i_cfg
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] OUT_LIM  = LINE_BITS'(64'hFFFF_FFFF);

    // configuration
    logic [PAT_W-1:0] r_pattern;
    logic [LEN_W-1:0] r_length;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // per-file state
    logic [PATTERN_MAX-1:0] r_vec;
    logic [LINE_BITS-1:0]   r_line;
    logic                   r_reported;

    // output register
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [LINE_OUT_W-1:0] r_out_line;

    logic                   adv;
    logic [PATTERN_MAX-1:0] n_vec;
    logic                   hit;
    logic [LINE_BITS-1:0]   n_line;
    logic                   has_result;
    logic                   n_found;
    logic [LINE_OUT_W-1:0]  n_out_line;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PAT_0_7:   r_pattern[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg.data;
                CFG_PAT_8_15:  r_pattern[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg.data;
                CFG_PAT_16_23: r_pattern[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg.data;
                CFG_PAT_24_31: r_pattern[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg.data;
                CFG_PAT_LEN:   r_length <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_of_file;
        end
    end

    assign n_line = (r_in_byte == NEWLINE_BYTE && r_line != LINE_SAT)
                  ? r_line + LINE_ONE : r_line;

    ssfm_prefix_update #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_prefix (
        .i_pattern (r_pattern),
        .i_length  (r_length),
        .i_vec     (r_vec),
        .i_byte    (r_in_byte),
        .o_vec     (n_vec),
        .o_hit     (hit)
    );

    assign has_result = !r_reported && (hit || r_in_last);
    assign n_found    = hit;
    assign n_out_line = !hit ? '0
                      : (n_line > OUT_LIM) ? {LINE_OUT_W{1'b1}}
                      : LINE_OUT_W'(n_line);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec      <= '0;
            r_line     <= LINE_ONE;
            r_reported <= 1'b0;
        end else if (adv) begin
            if (r_in_last) begin
                r_vec      <= '0;
                r_line     <= LINE_ONE;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_vec      <= n_vec;
                r_line     <= n_line;
                r_reported <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out_found <= n_found;
            r_out_line  <= n_out_line;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.line_number = r_out_line;

    // file end returns per-file state to its reset value
    a_file_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_vec == '0 && r_line == LINE_ONE && !r_reported)
        else $error("per-file state not cleared after last item");

    // a reported file produces no further results
    a_no_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_reported |-> !has_result)
        else $error("second result in one file");

    // a non-final match leaves the file marked as reported
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && has_result && n_found && !r_in_last |=> r_reported)
        else $error("match not recorded");

    // miss result carries line zero
    a_miss_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && has_result && !n_found |=> o_out.valid && o_out.line_number == '0)
        else $error("miss result with nonzero line");

endmodule
